// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define RSPD_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: name");

// antecedent at one edge implies consequent at the next edge
`define RSPD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: name");

`endif

// ===== design/rspd_pkg.sv =====
// ---------------------------------------------------------------------------
// rspd_pkg
// Operation and status codes of the slot pool.
// ---------------------------------------------------------------------------
package rspd_pkg;

    typedef logic [2:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_CREATE = 3'd0;
    localparam op_t OP_ADD    = 3'd1;
    localparam op_t OP_DROP   = 3'd2;
    localparam op_t OP_SETX   = 3'd3;
    localparam op_t OP_SETY   = 3'd4;
    localparam op_t OP_SETXY  = 3'd5;
    localparam op_t OP_READ   = 3'd6;
    localparam op_t OP_COMMIT = 3'd7;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_UNUSED = 2'd2;

endpackage

// ===== design/rspd_ram.sv =====
// ---------------------------------------------------------------------------
// rspd_ram
// Single write port, single registered read port RAM; a read that hits the
// address written in the same cycle returns the new data.
// ---------------------------------------------------------------------------
module rspd_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/refcounted_slot_pool_with_dirty_flag.sv =====
// ---------------------------------------------------------------------------
// refcounted_slot_pool_with_dirty_flag
// Slot allocator with a LIFO free list, per-slot use counts, positions and
// a pool-wide dirty flag.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries operation, slot_id, pos_x,
//   pos_y. Output channel (out_valid/out_ready) returns exactly one result
//   transaction per input transaction, in order.
//   The memory read is made on acceptance; the update and the result register
//   write follow when the update stage fires. Throughput: one transaction per
//   cycle while out_ready is high; a read that hits a slot or stack entry
//   written by the previous transaction is bypassed in the RAMs.
//   Reset: free list holds 0..SLOT_COUNT-1 (top is SLOT_COUNT-1), all counts
//   zero, dirty flag clear. No clearing pass: counts use per-slot valid bits
//   and the free list a low-water mark, so the block accepts right away.
//   Positions are undefined until written.
//   Stall: when out_ready is low the result register holds; one more
//   transaction is taken into the update stage, then in_ready drops.
// ---------------------------------------------------------------------------
module refcounted_slot_pool_with_dirty_flag
    import rspd_pkg::*;
#(
    parameter int SLOT_COUNT = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [4:0]  slot_id,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [4:0]  slot_out,
    output logic signed [31:0] pos_x_out,
    output logic signed [31:0] pos_y_out,
    output logic [5:0]  used_count,
    output logic [5:0]  free_count,
    output logic        refresh_pulse,
    output logic        slot_freed
);

    `include "assert_macros.svh"

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TOP_W = $clog2(SLOT_COUNT + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [TOP_W-1:0]      TOP_FULL = TOP_W'(SLOT_COUNT);

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [TOP_W-1:0]      top_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;

    // control state
    top_t                  top_reg, top_next;
    top_t                  low_reg, low_next;
    logic                  dirty_reg, dirty_next;
    logic [SLOT_COUNT-1:0] cnt_valid_reg;
    logic                  s1_valid_reg;
    logic                  out_valid_reg;

    // update stage payload
    op_t         s1_op_reg;
    logic [4:0]  s1_id_reg;
    idx_t        s1_idx_reg;
    logic        s1_rng_reg;
    logic [31:0] s1_x_reg;
    logic [31:0] s1_y_reg;
    logic        s1_cnt_vld_reg;
    logic        s1_stk_init_reg;
    idx_t        s1_stk_addr_reg;

    // result register
    status_t     r_status_reg, r_status_next;
    logic [4:0]  r_slot_reg, r_slot_next;
    logic [31:0] r_x_reg, r_x_next;
    logic [31:0] r_y_reg, r_y_next;
    logic [5:0]  r_used_reg, r_free_reg;
    logic        r_refresh_reg, r_refresh_next;
    logic        r_freed_reg, r_freed_next;

    // RAM ports
    logic        x_we, y_we, cnt_we, stk_we;
    idx_t        pos_waddr, cnt_waddr, stk_waddr;
    logic [31:0] x_wdata, y_wdata;
    cnt_t        cnt_wdata;
    idx_t        stk_wdata;
    logic [31:0] x_rdata, y_rdata;
    cnt_t        cnt_rdata;
    idx_t        stk_rdata;

    logic        fire, accept;
    idx_t        in_idx;
    logic        in_rng;
    idx_t        stk_raddr;
    logic        stk_re;
    cnt_t        cnt_cur;
    idx_t        stk_val;

    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;
    assign accept   = in_valid && in_ready;

    assign in_idx    = IDX_W'(32'(slot_id));
    assign in_rng    = 32'(slot_id) < SLOT_COUNT;
    assign stk_re    = accept && (top_next != '0);
    assign stk_raddr = (top_next != '0) ? IDX_W'(top_next - 1'b1) : '0;

    assign cnt_cur = s1_cnt_vld_reg ? cnt_rdata : '0;
    assign stk_val = s1_stk_init_reg ? s1_stk_addr_reg : stk_rdata;

    // update stage
    always_comb
    begin
        top_next       = top_reg;
        dirty_next     = dirty_reg;
        x_we           = 1'b0;
        y_we           = 1'b0;
        cnt_we         = 1'b0;
        stk_we         = 1'b0;
        pos_waddr      = s1_idx_reg;
        cnt_waddr      = s1_idx_reg;
        stk_waddr      = IDX_W'(top_reg);
        stk_wdata      = s1_idx_reg;
        x_wdata        = s1_x_reg;
        y_wdata        = s1_y_reg;
        cnt_wdata      = cnt_cur;
        r_status_next  = ST_OK;
        r_slot_next    = s1_id_reg;
        r_x_next       = '0;
        r_y_next       = '0;
        r_refresh_next = 1'b0;
        r_freed_next   = 1'b0;
        if (fire)
        begin
            case (s1_op_reg)
                OP_CREATE:
                begin
                    if (top_reg == '0)
                    begin
                        r_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        top_next    = top_reg - 1'b1;
                        pos_waddr   = stk_val;
                        cnt_waddr   = stk_val;
                        x_we        = 1'b1;
                        y_we        = 1'b1;
                        cnt_we      = 1'b1;
                        cnt_wdata   = CNT_ONE;
                        r_slot_next = 5'(32'(stk_val));
                    end
                end
                OP_ADD:
                begin
                    if (s1_rng_reg && (cnt_cur != '0) && (cnt_cur != CNT_MAX))
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_cur + 1'b1;
                    end
                end
                OP_DROP:
                begin
                    if (s1_rng_reg)
                    begin
                        if (cnt_cur == '0)
                        begin
                            r_status_next = ST_UNUSED;
                        end
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_cur - 1'b1;
                            if ((cnt_cur == CNT_ONE) && (top_reg < TOP_FULL))
                            begin
                                stk_we       = 1'b1;
                                top_next     = top_reg + 1'b1;
                                r_freed_next = 1'b1;
                            end
                        end
                    end
                end
                OP_SETX:
                begin
                    if (s1_rng_reg && (x_rdata != s1_x_reg))
                    begin
                        x_we       = 1'b1;
                        dirty_next = 1'b1;
                    end
                end
                OP_SETY:
                begin
                    if (s1_rng_reg && (y_rdata != s1_y_reg))
                    begin
                        y_we       = 1'b1;
                        dirty_next = 1'b1;
                    end
                end
                OP_SETXY:
                begin
                    if (s1_rng_reg && ((x_rdata != s1_x_reg) || (y_rdata != s1_y_reg)))
                    begin
                        x_we       = 1'b1;
                        y_we       = 1'b1;
                        dirty_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (s1_rng_reg)
                    begin
                        r_x_next = x_rdata;
                        r_y_next = y_rdata;
                    end
                end
                default:
                begin
                    if (dirty_reg)
                    begin
                        dirty_next     = 1'b0;
                        r_refresh_next = 1'b1;
                    end
                end
            endcase
        end
        low_next = (top_next < low_reg) ? top_next : low_reg;
    end

    rspd_ram #(.DEPTH(SLOT_COUNT), .WIDTH(32), .AW(IDX_W)) u_x_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (pos_waddr),
        .wdata (x_wdata),
        .re    (accept && in_rng),
        .raddr (in_idx),
        .rdata (x_rdata)
    );

    rspd_ram #(.DEPTH(SLOT_COUNT), .WIDTH(32), .AW(IDX_W)) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (pos_waddr),
        .wdata (y_wdata),
        .re    (accept && in_rng),
        .raddr (in_idx),
        .rdata (y_rdata)
    );

    rspd_ram #(.DEPTH(SLOT_COUNT), .WIDTH(COUNT_BITS), .AW(IDX_W)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (accept && in_rng),
        .raddr (in_idx),
        .rdata (cnt_rdata)
    );

    rspd_ram #(.DEPTH(SLOT_COUNT), .WIDTH(IDX_W), .AW(IDX_W)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= TOP_FULL;
            low_reg       <= TOP_FULL;
            dirty_reg     <= 1'b0;
            cnt_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg   <= top_next;
            low_reg   <= low_next;
            dirty_reg <= dirty_next;
            if (cnt_we)
            begin
                cnt_valid_reg[cnt_waddr] <= 1'b1;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= operation;
            s1_id_reg       <= slot_id;
            s1_idx_reg      <= in_idx;
            s1_rng_reg      <= in_rng;
            s1_x_reg        <= pos_x;
            s1_y_reg        <= pos_y;
            s1_cnt_vld_reg  <= in_rng && (cnt_valid_reg[in_idx]
                               || (cnt_we && (cnt_waddr == in_idx)));
            s1_stk_init_reg <= TOP_W'(32'(stk_raddr)) < low_next;
            s1_stk_addr_reg <= stk_raddr;
        end
        if (fire)
        begin
            r_status_reg  <= r_status_next;
            r_slot_reg    <= r_slot_next;
            r_x_reg       <= r_x_next;
            r_y_reg       <= r_y_next;
            r_used_reg    <= 6'(SLOT_COUNT - 32'(top_next));
            r_free_reg    <= 6'(32'(top_next));
            r_refresh_reg <= r_refresh_next;
            r_freed_reg   <= r_freed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = r_status_reg;
    assign slot_out      = r_slot_reg;
    assign pos_x_out     = r_x_reg;
    assign pos_y_out     = r_y_reg;
    assign used_count    = r_used_reg;
    assign free_count    = r_free_reg;
    assign refresh_pulse = r_refresh_reg;
    assign slot_freed    = r_freed_reg;

    `RSPD_ASSERT(a_low_le_top, (low_reg <= top_reg) && (top_reg <= TOP_FULL))
    `RSPD_ASSERT_NEXT(a_commit_clears, fire && (s1_op_reg == OP_COMMIT), !dirty_reg)
    `RSPD_ASSERT_NEXT(a_free_push, fire && r_freed_next, top_reg == ($past(top_reg) + 1'b1))

endmodule
